/* hdl/ils_pkg.sv */
// ============================================================================
// ils_pkg : indexed list store shared definitions
// Operation and status codes, field widths, defaults and the result record
// passed from the sequencer to the output stage.
// ============================================================================
package ils_pkg;

    // Payload widths fixed by the interface
    localparam int FUNC_BITS  = 3;
    localparam int INDEX_BITS = 9;
    localparam int WORD_BITS  = 32;
    localparam int STAT_BITS  = 2;
    localparam int CNT_BITS   = 9;

    // Widest stored word supported; used for zero extension
    localparam int WIDE_BITS  = 64;

    // Default sizing
    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_VALUE_BITS = 32;

    // Operation codes
    localparam logic [FUNC_BITS-1:0] FN_GET        = 3'd0;
    localparam logic [FUNC_BITS-1:0] FN_GET_REMOVE = 3'd1;
    localparam logic [FUNC_BITS-1:0] FN_REMOVE     = 3'd2;
    localparam logic [FUNC_BITS-1:0] FN_INSERT     = 3'd3;
    localparam logic [FUNC_BITS-1:0] FN_APPEND     = 3'd4;

    // Status codes
    localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd2;

    // One result record
    typedef struct packed {
        logic [WORD_BITS-1:0] read_value;
        logic [STAT_BITS-1:0] status;
        logic [CNT_BITS-1:0]  entry_count;
    } ils_result_t;

endpackage

/* hdl/indexed_list_store_unit.sv */
// ============================================================================
// indexed_list_store_unit : ordered list store with indexed insert/remove
// Top level: sequencer, entry RAM and output register.
// ============================================================================
// Usage:
//   Requests enter on in_valid/in_ready with func, index and value; each
//   request gives exactly one result on out_valid/out_ready carrying
//   read_value, status and entry_count.
//   Functions: get, get-and-remove, remove, insert at index, append. A
//   negative index counts back from the end; a magnitude at or above the
//   count is rejected with a range status. Insert and append report full.
//   Append, rejects and unused codes go from the request straight to the
//   result; get reads the entry first; remove, get-and-remove and insert
//   move the tail of the list, one entry per cycle through the single read
//   and single write port of the entry RAM. One request is in work at a
//   time; the next is taken the cycle after its result enters the output
//   register.
//   Reset clears the count to zero; the RAM is not cleared.
//   A stalled receiver holds the output register; one more request can
//   complete into the sequencer, which then waits with in_ready low.
// ============================================================================
module indexed_list_store_unit #(
    parameter int CAPACITY   = ils_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = ils_pkg::DEF_VALUE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [ils_pkg::FUNC_BITS-1:0]         func,
    input  logic signed [ils_pkg::INDEX_BITS-1:0] index,
    input  logic [ils_pkg::WORD_BITS-1:0]         value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ils_pkg::WORD_BITS-1:0]         read_value,
    output logic [ils_pkg::STAT_BITS-1:0]         status,
    output logic [ils_pkg::CNT_BITS-1:0]          entry_count
);

    import ils_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic                  res_valid;
    logic                  res_ready;
    ils_result_t           res;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;

    logic                  out_valid_reg;
    ils_result_t           out_res_reg;

    // Sequencer
    ils_seq #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_ready (in_ready),
        .req_func  (func),
        .req_index (index),
        .req_value (value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Entry RAM
    ils_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // Output register: loads when empty or being emptied
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = out_res_reg.read_value;
    assign status      = out_res_reg.status;
    assign entry_count = out_res_reg.entry_count;

endmodule

/* hdl/ils_mem.sv */
// ============================================================================
// ils_mem : entry storage
// Simple dual-port synchronous RAM, one write and one read port, read data
// registered. Contents undefined until written.
// ============================================================================
module ils_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= store_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/ils_seq.sv */
// ============================================================================
// ils_seq : request sequencer
// Resolves the index, reads the store, runs the one-entry-per-cycle shift
// for insert and remove, keeps the entry count and builds the result.
// ============================================================================
module ils_seq #(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request side
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [ils_pkg::FUNC_BITS-1:0]  req_func,
    input  logic [ils_pkg::INDEX_BITS-1:0] req_index,
    input  logic [ils_pkg::WORD_BITS-1:0]  req_value,
    // result side
    output logic                          res_valid,
    input  logic                          res_ready,
    output ils_pkg::ils_result_t           res,
    // store ports
    output logic                          mem_we,
    output logic [$clog2(CAPACITY)-1:0]   mem_waddr,
    output logic [VALUE_BITS-1:0]         mem_wdata,
    output logic [$clog2(CAPACITY)-1:0]   mem_raddr,
    input  logic [VALUE_BITS-1:0]         mem_rdata
);

    import ils_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > 10) ? CW : 10;

    // State codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_RDATA  = 3'd2;
    localparam logic [2:0] S_SHDN   = 3'd3;
    localparam logic [2:0] S_SHUP   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    // Control registers
    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  pend_reg, pend_next;

    // Payload registers
    logic [FUNC_BITS-1:0]  func_reg, func_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         ptr_reg, ptr_next;
    logic [AW-1:0]         wptr_reg, wptr_next;
    logic [WORD_BITS-1:0]  rdv_reg, rdv_next;
    logic [STAT_BITS-1:0]  st_reg, st_next;

    // Index resolution
    logic                  idx_neg;
    logic [9:0]            mag10;
    logic [CMP_W-1:0]      mag_x, cnt_x, pos_x;
    logic                  in_range;
    logic [AW-1:0]         pos_chk;
    logic                  list_full;

    // Width helpers
    logic [WIDE_BITS-1:0]  val_wide, rd_wide;
    logic [31:0]           cnt_wide;
    logic [CW-1:0]         ptr_dec, ptr_inc, pos_ext;

    assign idx_neg   = idx_reg[INDEX_BITS-1];
    assign mag10     = idx_neg ? (10'd512 - {1'b0, idx_reg}) : {1'b0, idx_reg};
    assign mag_x     = CMP_W'(mag10);
    assign cnt_x     = CMP_W'(count_reg);
    assign in_range  = mag_x < cnt_x;
    assign pos_x     = idx_neg ? (cnt_x - mag_x) : mag_x;
    assign pos_chk   = pos_x[AW-1:0];
    assign list_full = count_reg == CW'(CAPACITY);

    assign val_wide  = WIDE_BITS'(req_value);
    assign rd_wide   = WIDE_BITS'(mem_rdata);
    assign cnt_wide  = 32'(count_reg);
    assign ptr_dec   = ptr_reg - CW'(1);
    assign ptr_inc   = ptr_reg + CW'(1);
    assign pos_ext   = CW'(pos_reg);

    // Result record
    assign res.read_value  = rdv_reg;
    assign res.status      = st_reg;
    assign res.entry_count = cnt_wide[CNT_BITS-1:0];

    assign req_ready = state_reg == S_IDLE;
    assign res_valid = state_reg == S_FINISH;

    // Next-state and store access
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        func_next  = func_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        pos_next   = pos_reg;
        ptr_next   = ptr_reg;
        wptr_next  = wptr_reg;
        rdv_next   = rdv_reg;
        st_next    = st_reg;
        mem_we     = 1'b0;
        mem_waddr  = wptr_reg;
        mem_wdata  = mem_rdata;
        mem_raddr  = pos_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next  = req_func;
                    idx_next   = req_index;
                    val_next   = val_wide[VALUE_BITS-1:0];
                    rdv_next   = '0;
                    st_next    = ST_OK;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                mem_raddr = pos_chk;
                unique case (func_reg)
                    FN_GET, FN_GET_REMOVE, FN_REMOVE:
                    begin
                        if (!in_range)
                        begin
                            st_next    = ST_RANGE;
                            state_next = S_FINISH;
                        end
                        else if (func_reg == FN_REMOVE)
                        begin
                            pos_next   = pos_chk;
                            ptr_next   = CW'(pos_chk) + CW'(1);
                            pend_next  = 1'b0;
                            state_next = S_SHDN;
                        end
                        else
                        begin
                            pos_next   = pos_chk;
                            state_next = S_RDATA;
                        end
                    end
                    FN_INSERT:
                    begin
                        if (!in_range)
                        begin
                            st_next    = ST_RANGE;
                            state_next = S_FINISH;
                        end
                        else if (list_full)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            pos_next   = pos_chk;
                            ptr_next   = count_reg;
                            pend_next  = 1'b0;
                            state_next = S_SHUP;
                        end
                    end
                    FN_APPEND:
                    begin
                        if (list_full)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            mem_wdata  = val_reg;
                            count_next = count_reg + CW'(1);
                        end
                        state_next = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            // Read data for get operations arrives here
            S_RDATA:
            begin
                rdv_next = rd_wide[WORD_BITS-1:0];
                if (func_reg == FN_GET)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    ptr_next   = pos_ext + CW'(1);
                    pend_next  = 1'b0;
                    state_next = S_SHDN;
                end
            end

            // Shift down: read entry ptr, write it one place lower next cycle
            S_SHDN:
            begin
                mem_raddr = ptr_reg[AW-1:0];
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                end
                if (ptr_reg < count_reg)
                begin
                    pend_next = 1'b1;
                    wptr_next = ptr_dec[AW-1:0];
                    ptr_next  = ptr_inc;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_FINISH;
                    end
                end
            end

            // Shift up: read entry ptr-1, write it at ptr next cycle
            S_SHUP:
            begin
                mem_raddr = ptr_dec[AW-1:0];
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                end
                if (ptr_reg > pos_ext)
                begin
                    pend_next = 1'b1;
                    wptr_next = ptr_reg[AW-1:0];
                    ptr_next  = ptr_dec;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = pos_reg;
                        mem_wdata  = val_reg;
                        count_next = count_reg + CW'(1);
                        state_next = S_FINISH;
                    end
                end
            end

            S_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        idx_reg  <= idx_next;
        val_reg  <= val_next;
        pos_reg  <= pos_next;
        ptr_reg  <= ptr_next;
        wptr_reg <= wptr_next;
        rdv_reg  <= rdv_next;
        st_reg   <= st_next;
    end

    // Count never passes capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // Shift-down writes stay inside the list
    a_shdn_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHDN && pend_reg) |-> (CW'(wptr_reg) < count_reg))
        else $error("shift-down write outside list");

    // Only get operations return data
    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (func_reg == FN_REMOVE || func_reg == FN_INSERT
                       || func_reg == FN_APPEND)) |-> (rdv_reg == '0))
        else $error("read value set on non-get operation");

    // A finished result stays until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(count_reg)))
        else $error("result dropped while stalled");

endmodule
